// ----- rtl/core/hsps_pkg.sv -----
// hsps_pkg: widths, codes, types and reset values for the hid slot poll scheduler
// no dependencies; used by the channel interfaces and every module of the block

package hsps_pkg;

    localparam int NUM_SLOTS_DEF = 4;

    // field widths
    localparam int OP_W       = 3;
    localparam int ADDR_W     = 7;
    localparam int IFACE_W    = 4;
    localparam int PROTO_W    = 2;
    localparam int STATUS_W   = 2;
    localparam int OSLOT_W    = 2;
    localparam int DTYPE_W    = 3;
    localparam int MASK_W     = 4;
    localparam int TIMER_W    = 16;
    localparam int RATE_W     = 10;
    localparam int CAP_W      = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_RATE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_RATE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_CAP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_BASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_STEP = 3'd4;

    // configuration reset values
    localparam logic [RATE_W-1:0] TOUCH_RATE_RST   = 10'd5;
    localparam logic [RATE_W-1:0] NORMAL_RATE_RST  = 10'd20;
    localparam logic [CAP_W-1:0]  TIMER_CAP_RST    = 14'd10000;
    localparam logic [RATE_W-1:0] STARTUP_BASE_RST = 10'd10;
    localparam logic [RATE_W-1:0] STARTUP_STEP_RST = 10'd500;

    // interface protocol codes at mount
    localparam logic [PROTO_W-1:0] PROTO_NONE  = 2'd0;
    localparam logic [PROTO_W-1:0] PROTO_KBD   = 2'd1;
    localparam logic [PROTO_W-1:0] PROTO_MOUSE = 2'd2;
    localparam logic [PROTO_W-1:0] PROTO_OTHER = 2'd3;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 3'd0,
        OP_MOUNT   = 3'd1,
        OP_UNMOUNT = 3'd2,
        OP_REPORT  = 3'd3,
        OP_POLL    = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_IGNORED   = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [DTYPE_W-1:0] {
        DT_NONE  = 3'd0,
        DT_KBD   = 3'd1,
        DT_MOUSE = 3'd2,
        DT_PAD   = 3'd3,
        DT_TOUCH = 3'd4
    } t_dev_type;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_LOAD,
        S_DONE
    } t_state;

    // shared timer unit operations
    typedef enum logic [1:0] {
        TU_TICK,
        TU_DUE,
        TU_START
    } t_tu_op;

    typedef struct packed {
        logic [RATE_W-1:0] touch_rate;
        logic [RATE_W-1:0] normal_rate;
        logic [CAP_W-1:0]  timer_cap;
        logic [RATE_W-1:0] startup_base;
        logic [RATE_W-1:0] startup_step;
    } t_cfg;

    // slot table write controls from the sequencer
    typedef struct packed {
        logic load;      // mount: fill slot from latched word
        logic clr;       // unmount: clear slot, mark pending
        logic tmr_we;    // timer takes timer unit result
        logic pend_we;
        logic pend_val;
        logic led_we;    // first led push done
    } t_slot_wr;

endpackage

// ----- rtl/core/hsps_in_if.sv -----
// hsps_in_if: command word channel into the hid slot poll scheduler
// depends on hsps_pkg for field widths

interface hsps_in_if;
    import hsps_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [ADDR_W-1:0]  usb_addr;
    logic [IFACE_W-1:0] iface;
    logic [PROTO_W-1:0] protocol;
    logic               is_touch;
    logic               is_gamepad;
    logic [MASK_W-1:0]  accept_mask;

    modport source (
        output valid, op, usb_addr, iface, protocol, is_touch, is_gamepad, accept_mask,
        input  ready
    );

    modport sink (
        input  valid, op, usb_addr, iface, protocol, is_touch, is_gamepad, accept_mask,
        output ready
    );
endinterface

// ----- rtl/core/hsps_out_if.sv -----
// hsps_out_if: result word channel out of the hid slot poll scheduler
// depends on hsps_pkg for field widths

interface hsps_out_if;
    import hsps_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [OSLOT_W-1:0]  slot;
    logic [DTYPE_W-1:0]  dev_type;
    logic [MASK_W-1:0]   request_mask;
    logic [MASK_W-1:0]   led_mask;

    modport source (
        output valid, status, slot, dev_type, request_mask, led_mask,
        input  ready
    );

    modport sink (
        input  valid, status, slot, dev_type, request_mask, led_mask,
        output ready
    );
endinterface

// ----- rtl/core/hid_slot_poll_scheduler.sv -----
// hid_slot_poll_scheduler: top level, slot table, sequencer and result register
// depends on hsps_pkg, hsps_in_if, hsps_out_if, hsps_timer_unit, hsps_slot_pick

// Usage
//   i_in carries one command word: tick, mount, unmount, report received or poll,
//   with device address, interface, protocol, touch/gamepad flags and accept mask.
//   o_res returns exactly one result word per command: status, slot, device type,
//   request mask and led mask. Both channels move a word when valid and ready are high.
//   i_cfg_we/i_cfg_idx/i_cfg_data write the five rate, cap and delay registers; write them
//   only while no command is in flight.
// Timing
//   i_in.ready is high only in idle, one command is worked on at a time.
//   Tick and poll walk all NUM_SLOTS slots through the one shared timer unit,
//   one slot per cycle. Unmount and report walk until the first matching slot,
//   or to the last slot if none matches. Mount goes through accept, pick and delay
//   product, slot load and result; a refused mount skips the slot load.
//   An unknown op code returns all zeros.
// Reset and stall
//   Synchronous reset clears every slot and loads the default register values.
//   The result word holds on o_res while o_res.ready is low, and no new
//   command is taken until it has gone.

module hid_slot_poll_scheduler #(
    parameter int NUM_SLOTS = hsps_pkg::NUM_SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hsps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hsps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    hsps_in_if.sink                         i_in,
    hsps_out_if.source                      o_res
);
    import hsps_pkg::*;

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int MUL_W  = SLOT_W + 1;
    localparam int PROD_W = RATE_W + MUL_W;

    // configuration registers
    t_cfg r_cfg;

    // slot table
    logic [NUM_SLOTS-1:0]       r_active;
    logic [NUM_SLOTS-1:0]       r_pending;
    logic [NUM_SLOTS-1:0]       r_leds;
    logic [ADDR_W-1:0]          r_slot_addr  [NUM_SLOTS];
    logic [IFACE_W-1:0]         r_slot_iface [NUM_SLOTS];
    t_dev_type                  r_slot_type  [NUM_SLOTS];
    logic signed [TIMER_W-1:0]  r_slot_timer [NUM_SLOTS];

    // sequencer
    t_state             r_state;
    t_state             n_state;
    logic [SLOT_W-1:0]  r_idx;

    // latched command word
    t_op                r_op;
    logic [ADDR_W-1:0]  r_addr_in;
    logic [IFACE_W-1:0] r_iface_in;
    logic [PROTO_W-1:0] r_proto;
    logic               r_touch;
    logic               r_pad;
    logic [MASK_W-1:0]  r_accept;

    // mount pick results
    logic [SLOT_W-1:0]  r_pslot;
    t_dev_type          r_ptype;
    logic [PROD_W-1:0]  r_prod;

    // result register
    t_status            r_status;
    logic [OSLOT_W-1:0] r_oslot;
    t_dev_type          r_otype;
    logic [MASK_W-1:0]  r_req;
    logic [MASK_W-1:0]  r_led;

    // datapath wires
    logic                      in_acc;
    logic                      last;
    logic                      match;
    logic                      is_find;
    logic                      due;
    logic                      acc_bit;
    logic [MASK_W-1:0]         bit_mask;
    logic signed [TIMER_W-1:0] rd_timer;
    t_dev_type                 rd_type;
    t_tu_op                    tu_op;
    logic signed [TIMER_W-1:0] tu_timer;
    logic                      tu_below;
    t_slot_wr                  wr;
    logic [SLOT_W-1:0]         pk_slot;
    t_dev_type                 pk_type;
    t_status                   pk_status;
    logic [MUL_W-1:0]          mul_k;

    assign in_acc   = i_in.valid && i_in.ready;
    assign last     = r_idx == SLOT_W'(NUM_SLOTS - 1);
    assign rd_timer = r_slot_timer[r_idx];
    assign rd_type  = r_slot_type[r_idx];
    assign is_find  = (r_op == OP_UNMOUNT) || (r_op == OP_REPORT);
    assign match    = r_active[r_idx] && (r_slot_addr[r_idx] == r_addr_in)
                      && (r_slot_iface[r_idx] == r_iface_in);
    // mask bit of the scanned slot, zero for slots past the 4-bit masks
    assign bit_mask = MASK_W'(1) << r_idx;
    assign acc_bit  = |(r_accept & bit_mask);
    assign due      = r_active[r_idx] && !r_pending[r_idx] && !tu_below;
    assign mul_k    = MUL_W'(pk_slot) + MUL_W'(2);

    hsps_timer_unit #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_tmr (
        .i_op    (tu_op),
        .i_timer (rd_timer),
        .i_type  (rd_type),
        .i_cfg   (r_cfg),
        .i_prod  (r_prod),
        .o_timer (tu_timer),
        .o_below (tu_below)
    );

    hsps_slot_pick #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_pick (
        .i_active (r_active),
        .i_proto  (r_proto),
        .i_touch  (r_touch),
        .i_pad    (r_pad),
        .o_slot   (pk_slot),
        .o_type   (pk_type),
        .o_status (pk_status)
    );

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.touch_rate   <= TOUCH_RATE_RST;
            r_cfg.normal_rate  <= NORMAL_RATE_RST;
            r_cfg.timer_cap    <= TIMER_CAP_RST;
            r_cfg.startup_base <= STARTUP_BASE_RST;
            r_cfg.startup_step <= STARTUP_STEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TOUCH_RATE:   r_cfg.touch_rate   <= i_cfg_data[RATE_W-1:0];
                CFG_NORMAL_RATE:  r_cfg.normal_rate  <= i_cfg_data[RATE_W-1:0];
                CFG_TIMER_CAP:    r_cfg.timer_cap    <= i_cfg_data[CAP_W-1:0];
                CFG_STARTUP_BASE: r_cfg.startup_base <= i_cfg_data[RATE_W-1:0];
                CFG_STARTUP_STEP: r_cfg.startup_step <= i_cfg_data[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    unique case (t_op'(i_in.op))
                        OP_TICK, OP_POLL, OP_UNMOUNT, OP_REPORT: n_state = S_SCAN;
                        OP_MOUNT: n_state = S_PICK;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                // lookups stop at the first matching slot
                if (last || (is_find && match)) begin
                    n_state = S_DONE;
                end
            end
            S_PICK: n_state = (pk_status == ST_OK) ? S_LOAD : S_DONE;
            S_LOAD: n_state = S_DONE;
            S_DONE: begin
                if (o_res.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs: timer unit op and slot table writes
    always_comb begin
        tu_op = TU_TICK;
        wr    = '0;
        unique case (r_state)
            S_SCAN: begin
                unique case (r_op)
                    OP_TICK: begin
                        tu_op     = TU_TICK;
                        wr.tmr_we = (rd_type != DT_NONE) && tu_below;
                    end
                    OP_POLL: begin
                        // refused request: timer restarts from zero
                        tu_op       = TU_DUE;
                        wr.pend_we  = due;
                        wr.pend_val = acc_bit;
                        wr.tmr_we   = due && !acc_bit;
                        wr.led_we   = due && (rd_type == DT_KBD) && !r_leds[r_idx];
                    end
                    OP_UNMOUNT: wr.clr = match;
                    OP_REPORT: begin
                        tu_op       = TU_DUE;
                        wr.pend_we  = match;
                        wr.pend_val = 1'b0;
                        wr.tmr_we   = match;
                    end
                    default: ;
                endcase
            end
            S_LOAD: begin
                tu_op   = TU_START;
                wr.load = 1'b1;
            end
            default: ;
        endcase
    end

    assign i_in.ready  = r_state == S_IDLE;
    assign o_res.valid = r_state == S_DONE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // slot table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= '0;
            r_pending <= '0;
            r_leds    <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_slot_addr[i]  <= '0;
                r_slot_iface[i] <= '0;
                r_slot_type[i]  <= DT_NONE;
                r_slot_timer[i] <= '0;
            end
        end else if (wr.load) begin
            r_active[r_pslot]     <= 1'b1;
            r_pending[r_pslot]    <= 1'b0;
            r_leds[r_pslot]       <= 1'b0;
            r_slot_addr[r_pslot]  <= r_addr_in;
            r_slot_iface[r_pslot] <= r_iface_in;
            r_slot_type[r_pslot]  <= r_ptype;
            r_slot_timer[r_pslot] <= tu_timer;
        end else if (wr.clr) begin
            // freed slot stays pending so it is never polled
            r_active[r_idx]     <= 1'b0;
            r_pending[r_idx]    <= 1'b1;
            r_leds[r_idx]       <= 1'b0;
            r_slot_addr[r_idx]  <= '0;
            r_slot_iface[r_idx] <= '0;
            r_slot_type[r_idx]  <= DT_NONE;
            r_slot_timer[r_idx] <= '0;
        end else begin
            if (wr.tmr_we) begin
                r_slot_timer[r_idx] <= tu_timer;
            end
            if (wr.pend_we) begin
                r_pending[r_idx] <= wr.pend_val;
            end
            if (wr.led_we) begin
                r_leds[r_idx] <= 1'b1;
            end
        end
    end

    // command latch, scan index, pick results and result word
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op       <= t_op'(i_in.op);
            r_addr_in  <= i_in.usb_addr;
            r_iface_in <= i_in.iface;
            r_proto    <= i_in.protocol;
            r_touch    <= i_in.is_touch;
            r_pad      <= i_in.is_gamepad;
            r_accept   <= i_in.accept_mask;
            r_idx      <= '0;
            r_status   <= ST_OK;
            r_oslot    <= '0;
            r_otype    <= DT_NONE;
            r_req      <= '0;
            r_led      <= '0;
        end else if (r_state == S_SCAN) begin
            r_idx <= r_idx + SLOT_W'(1);
            if (r_op == OP_POLL) begin
                if (wr.pend_we && wr.pend_val) begin
                    r_req <= r_req | bit_mask;
                end
                if (wr.led_we) begin
                    r_led <= r_led | bit_mask;
                end
            end else if (is_find) begin
                if (match) begin
                    r_oslot <= r_idx[OSLOT_W-1:0];
                    r_otype <= rd_type;
                end else if (last) begin
                    r_status <= ST_NOT_FOUND;
                end
            end
        end else if (r_state == S_PICK) begin
            r_status <= pk_status;
            r_pslot  <= pk_slot;
            r_ptype  <= pk_type;
            // start-up delay product, (slot + 2) * step
            r_prod   <= PROD_W'(mul_k) * PROD_W'(r_cfg.startup_step);
            if (pk_status == ST_OK) begin
                r_oslot <= pk_slot[OSLOT_W-1:0];
                r_otype <= pk_type;
            end
        end
    end

    assign o_res.status       = r_status;
    assign o_res.slot         = r_oslot;
    assign o_res.dev_type     = r_otype;
    assign o_res.request_mask = r_req;
    assign o_res.led_mask     = r_led;
endmodule

// ----- rtl/core/hsps_timer_unit.sv -----
// hsps_timer_unit: shared add/compare unit for slot timers (tick, due check, start-up load)
// depends on hsps_pkg

module hsps_timer_unit #(
    parameter int NUM_SLOTS = hsps_pkg::NUM_SLOTS_DEF,
    localparam int PROD_W = hsps_pkg::RATE_W + $clog2(NUM_SLOTS) + 1
) (
    input  hsps_pkg::t_tu_op                    i_op,
    input  logic signed [hsps_pkg::TIMER_W-1:0] i_timer,
    input  hsps_pkg::t_dev_type                 i_type,
    input  hsps_pkg::t_cfg                      i_cfg,
    input  logic [PROD_W-1:0]                   i_prod,
    output logic signed [hsps_pkg::TIMER_W-1:0] o_timer,
    output logic                                o_below
);
    import hsps_pkg::*;

    localparam int SUM_W = TIMER_W + 1;

    logic [TIMER_W-1:0] lim;
    logic [SUM_W-1:0]   add_a;
    logic [SUM_W-1:0]   add_b;
    logic [SUM_W-1:0]   sum;
    logic [SUM_W-1:0]   neg;

    // limit: cap while ticking, report rate otherwise
    always_comb begin
        if (i_op == TU_TICK) begin
            lim = TIMER_W'(i_cfg.timer_cap);
        end else if (i_type == DT_TOUCH) begin
            lim = TIMER_W'(i_cfg.touch_rate);
        end else begin
            lim = TIMER_W'(i_cfg.normal_rate);
        end
    end

    assign o_below = i_timer < $signed(lim);

    always_comb begin
        if (i_op == TU_START) begin
            add_a = SUM_W'(i_cfg.startup_base);
            add_b = SUM_W'(i_prod);
        end else begin
            add_a = {i_timer[TIMER_W-1], i_timer};
            add_b = SUM_W'(1);
        end
    end

    assign sum = add_a + add_b;
    assign neg = -sum;

    always_comb begin
        unique case (i_op)
            TU_TICK:  o_timer = o_below ? $signed(sum[TIMER_W-1:0]) : i_timer;
            TU_START: o_timer = $signed(neg[TIMER_W-1:0]);
            default:  o_timer = '0;
        endcase
    end
endmodule

// ----- rtl/core/hsps_slot_pick.sv -----
// hsps_slot_pick: slot allocation and device typing for a mount
// depends on hsps_pkg

module hsps_slot_pick #(
    parameter int NUM_SLOTS = hsps_pkg::NUM_SLOTS_DEF,
    localparam int SLOT_W = $clog2(NUM_SLOTS)
) (
    input  logic [NUM_SLOTS-1:0]         i_active,
    input  logic [hsps_pkg::PROTO_W-1:0] i_proto,
    input  logic                         i_touch,
    input  logic                         i_pad,
    output logic [SLOT_W-1:0]            o_slot,
    output hsps_pkg::t_dev_type          o_type,
    output hsps_pkg::t_status            o_status
);
    import hsps_pkg::*;

    logic [SLOT_W-1:0] hi_slot;
    logic              hi_found;
    logic [SLOT_W-1:0] pref;

    // highest free slot
    always_comb begin
        hi_slot  = '0;
        hi_found = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!i_active[i]) begin
                hi_slot  = SLOT_W'(i);
                hi_found = 1'b1;
            end
        end
    end

    // preferred slot by protocol, else the highest free one
    always_comb begin
        priority if (i_proto == PROTO_KBD && !i_active[0]) begin
            pref = SLOT_W'(0);
        end else if (i_proto == PROTO_MOUSE && !i_active[1]) begin
            pref = SLOT_W'(1);
        end else if (i_proto == PROTO_NONE && !i_active[2]) begin
            pref = SLOT_W'(2);
        end else if (i_proto == PROTO_NONE && !i_active[3]) begin
            pref = SLOT_W'(3);
        end else begin
            pref = hi_slot;
        end
    end

    always_comb begin
        o_slot   = pref;
        o_type   = DT_PAD;
        o_status = ST_OK;
        if (!hi_found) begin
            o_status = ST_NO_FREE;
        end else begin
            unique case (i_proto)
                PROTO_KBD:   o_type = DT_KBD;
                PROTO_MOUSE: o_type = DT_MOUSE;
                PROTO_OTHER: o_type = DT_PAD;
                default: begin
                    if (i_touch) begin
                        o_type = DT_TOUCH;
                        // touch panels prefer the last fixed slot
                        if (!i_active[3]) begin
                            o_slot = SLOT_W'(3);
                        end
                    end else if (!i_pad) begin
                        o_status = ST_IGNORED;
                    end
                end
            endcase
        end
    end
endmodule

// ----- tb/sv/testbench.sv -----
// testbench: self-checking bench for the hid slot poll scheduler, with its own slot table model
// depends on hsps_pkg, hsps_in_if, hsps_out_if and hid_slot_poll_scheduler

module testbench;
    import hsps_pkg::*;

    localparam int SLOTS = NUM_SLOTS_DEF;

    // op codes the block does not define, they must come back as an all-zero word
    localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

    // receiver holds off once for a long stretch so the block backs up into the sender
    localparam int HOLD_AFTER  = 400;
    localparam int HOLD_CYCLES = 300;

    // one command word as the sender drives it
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [ADDR_W-1:0]  addr;
        logic [IFACE_W-1:0] iface;
        logic [PROTO_W-1:0] protocol;
        logic               is_touch;
        logic               is_gamepad;
        logic [MASK_W-1:0]  accept;
    } t_cmd;

    // one result word as it should leave the block
    typedef struct packed {
        t_status            status;
        logic [OSLOT_W-1:0] slot;
        t_dev_type          dev_type;
        logic [MASK_W-1:0]  req;
        logic [MASK_W-1:0]  led;
    } t_res;

    // directed rows: a word checked by the model, a word with its result typed in,
    // or a new set of register values
    typedef enum logic [1:0] {
        ROW_WORD,
        ROW_TYPED,
        ROW_REGS
    } t_row_kind;

    typedef struct packed {
        t_row_kind kind;
        t_cmd      cmd;
        t_cfg      regs;
        t_res      want;
    } t_plan_row;

    localparam t_res ZERO_RES  = '{ST_OK, 2'd0, DT_NONE, 4'h0, 4'h0};
    localparam t_res MISS_RES  = '{ST_NOT_FOUND, 2'd0, DT_NONE, 4'h0, 4'h0};
    localparam t_res FULL_RES  = '{ST_NO_FREE, 2'd0, DT_NONE, 4'h0, 4'h0};
    localparam t_res SKIP_RES  = '{ST_IGNORED, 2'd0, DT_NONE, 4'h0, 4'h0};
    localparam t_cmd NO_CMD    = '0;
    localparam t_cfg KEEP_REGS = '0;

    // fastest schedule: every typed slot is due one tick after mount
    localparam t_cfg FAST_REGS = '{10'd1, 10'd1, 14'd16383, 10'd0, 10'd0};

    localparam int PLAN_ROWS = 26;
    localparam t_plan_row PLAN [PLAN_ROWS] = '{
        // empty table, defaults: nothing due, nothing to match
        '{ROW_TYPED, '{OP_POLL, 7'd0, 4'd0, PROTO_NONE, 1'b0, 1'b0, 4'hF}, KEEP_REGS,
          ZERO_RES},
        '{ROW_TYPED, '{OP_UNDEF_LO, 7'd127, 4'd15, PROTO_OTHER, 1'b1, 1'b1, 4'hF},
          KEEP_REGS, ZERO_RES},
        '{ROW_TYPED, '{OP_UNDEF_HI, 7'd0, 4'd0, PROTO_NONE, 1'b0, 1'b0, 4'h0}, KEEP_REGS,
          ZERO_RES},
        '{ROW_TYPED, '{OP_UNMOUNT, 7'd5, 4'd1, PROTO_NONE, 1'b0, 1'b0, 4'h0}, KEEP_REGS,
          MISS_RES},
        '{ROW_TYPED, '{OP_REPORT, 7'd5, 4'd1, PROTO_NONE, 1'b0, 1'b0, 4'h0}, KEEP_REGS,
          MISS_RES},
        '{ROW_REGS, NO_CMD, FAST_REGS, ZERO_RES},
        // fill every slot: keyboard 0, mouse 1, touch moved up to 3, gamepad 2
        '{ROW_TYPED, '{OP_MOUNT, 7'd127, 4'd15, PROTO_KBD, 1'b1, 1'b1, 4'h0}, KEEP_REGS,
          '{ST_OK, 2'd0, DT_KBD, 4'h0, 4'h0}},
        '{ROW_TYPED, '{OP_MOUNT, 7'd0, 4'd0, PROTO_MOUSE, 1'b0, 1'b0, 4'h0}, KEEP_REGS,
          '{ST_OK, 2'd1, DT_MOUSE, 4'h0, 4'h0}},
        '{ROW_TYPED, '{OP_MOUNT, 7'd3, 4'd0, PROTO_NONE, 1'b0, 1'b0, 4'h0}, KEEP_REGS,
          SKIP_RES},
        '{ROW_TYPED, '{OP_MOUNT, 7'd9, 4'd2, PROTO_NONE, 1'b1, 1'b0, 4'h0}, KEEP_REGS,
          '{ST_OK, 2'd3, DT_TOUCH, 4'h0, 4'h0}},
        '{ROW_TYPED, '{OP_MOUNT, 7'd42, 4'd3, PROTO_NONE, 1'b0, 1'b1, 4'h0}, KEEP_REGS,
          '{ST_OK, 2'd2, DT_PAD, 4'h0, 4'h0}},
        // table full: no free slot wins over the ignore check
        '{ROW_TYPED, '{OP_MOUNT, 7'd1, 4'd0, PROTO_KBD, 1'b0, 1'b0, 4'h0}, KEEP_REGS,
          FULL_RES},
        '{ROW_TYPED, '{OP_MOUNT, 7'd1, 4'd0, PROTO_NONE, 1'b0, 1'b0, 4'h0}, KEEP_REGS,
          FULL_RES},
        '{ROW_TYPED, '{OP_TICK, 7'd0, 4'd0, PROTO_NONE, 1'b0, 1'b0, 4'h0}, KEEP_REGS,
          ZERO_RES},
        // all due: first led push, two granted, two refused
        '{ROW_WORD, '{OP_POLL, 7'd0, 4'd0, PROTO_NONE, 1'b0, 1'b0, 4'h5}, KEEP_REGS,
          ZERO_RES},
        '{ROW_WORD, '{OP_POLL, 7'd0, 4'd0, PROTO_NONE, 1'b0, 1'b0, 4'hF}, KEEP_REGS,
          ZERO_RES},
        '{ROW_TYPED, '{OP_REPORT, 7'd127, 4'd15, PROTO_NONE, 1'b0, 1'b0, 4'h0}, KEEP_REGS,
          '{ST_OK, 2'd0, DT_KBD, 4'h0, 4'h0}},
        '{ROW_TYPED, '{OP_UNMOUNT, 7'd0, 4'd0, PROTO_NONE, 1'b0, 1'b0, 4'h0}, KEEP_REGS,
          '{ST_OK, 2'd1, DT_MOUSE, 4'h0, 4'h0}},
        // protocol three skips the preferred slots, same address as slot 0
        '{ROW_TYPED, '{OP_MOUNT, 7'd127, 4'd15, PROTO_OTHER, 1'b0, 1'b0, 4'h0}, KEEP_REGS,
          '{ST_OK, 2'd1, DT_PAD, 4'h0, 4'h0}},
        '{ROW_TYPED, '{OP_UNMOUNT, 7'd42, 4'd3, PROTO_NONE, 1'b0, 1'b0, 4'h0}, KEEP_REGS,
          '{ST_OK, 2'd2, DT_PAD, 4'h0, 4'h0}},
        // touch stays in slot 2 because slot 3 is taken
        '{ROW_TYPED, '{OP_MOUNT, 7'd9, 4'd5, PROTO_NONE, 1'b1, 1'b0, 4'h0}, KEEP_REGS,
          '{ST_OK, 2'd2, DT_TOUCH, 4'h0, 4'h0}},
        // duplicates: the lowest matching slot goes first
        '{ROW_TYPED, '{OP_UNMOUNT, 7'd127, 4'd15, PROTO_NONE, 1'b0, 1'b0, 4'h0}, KEEP_REGS,
          '{ST_OK, 2'd0, DT_KBD, 4'h0, 4'h0}},
        '{ROW_TYPED, '{OP_UNMOUNT, 7'd127, 4'd15, PROTO_NONE, 1'b0, 1'b0, 4'h0}, KEEP_REGS,
          '{ST_OK, 2'd1, DT_PAD, 4'h0, 4'h0}},
        '{ROW_TYPED, '{OP_TICK, 7'd0, 4'd0, PROTO_NONE, 1'b0, 1'b0, 4'h0}, KEEP_REGS,
          ZERO_RES},
        // freed slots stay quiet, both touch slots due
        '{ROW_WORD, '{OP_POLL, 7'd0, 4'd0, PROTO_NONE, 1'b0, 1'b0, 4'hF}, KEEP_REGS,
          ZERO_RES},
        '{ROW_TYPED, '{OP_REPORT, 7'd9, 4'd2, PROTO_NONE, 1'b0, 1'b0, 4'h0}, KEEP_REGS,
          '{ST_OK, 2'd3, DT_TOUCH, 4'h0, 4'h0}}
    };

    // register sets for the random phases: defaults, minimum, a quick mix, large values,
    // a cap below the normal rate; the last one is drawn at run time
    localparam int PHASES = 6;
    localparam t_cfg PHASE_REGS [PHASES] = '{
        '{TOUCH_RATE_RST, NORMAL_RATE_RST, TIMER_CAP_RST, STARTUP_BASE_RST, STARTUP_STEP_RST},
        '{10'd1, 10'd1, 14'd1, 10'd0, 10'd0},
        '{10'd3, 10'd7, 14'd16383, 10'd0, 10'd1},
        '{10'd1000, 10'd1000, 14'd16383, 10'd1000, 10'd1000},
        '{10'd2, 10'd8, 14'd5, 10'd1, 10'd2},
        '{10'd1, 10'd1, 14'd1, 10'd0, 10'd0}
    };
    localparam int PHASE_WORDS [PHASES] = '{150, 250, 250, 100, 250, 200};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    hsps_in_if  cmd_ch ();
    hsps_out_if res_ch ();

    hid_slot_poll_scheduler u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (cmd_ch),
        .o_res      (res_ch)
    );

    always #10 i_clk = ~i_clk;

    // model copy of the slot table and the registers, reset state
    logic                      seat_live  [SLOTS] = '{default: 1'b0};
    logic [ADDR_W-1:0]         seat_addr  [SLOTS] = '{default: '0};
    logic [IFACE_W-1:0]        seat_iface [SLOTS] = '{default: '0};
    t_dev_type                 seat_kind  [SLOTS] = '{default: DT_NONE};
    logic                      seat_busy  [SLOTS] = '{default: 1'b0};
    logic signed [TIMER_W-1:0] seat_clock [SLOTS] = '{default: '0};
    logic                      seat_led   [SLOTS] = '{default: 1'b0};
    t_cfg regs = PHASE_REGS[0];

    t_res outcome_q [$];
    int   mismatches = 0;
    int   n_words = 0;
    int   n_placed = 0;
    int   n_granted = 0;
    int   n_leds = 0;
    int   n_settings = 0;
    bit   offering = 1'b0;
    bit   tx_calm = 1'b0;
    bit   rx_calm = 1'b0;

    // what the block must answer for one word, and how its slot table moves
    function automatic t_res scheduler_outcome(input t_cmd c);
        t_res      r;
        int        s;
        int        delay;
        t_dev_type kind;
        logic      keep;
        r = ZERO_RES;
        s = -1;
        case (c.op)
            OP_TICK: begin
                for (int i = 0; i < SLOTS; i++)
                    if (seat_kind[i] != DT_NONE && int'(seat_clock[i]) < int'(regs.timer_cap))
                        seat_clock[i] = seat_clock[i] + 16'sd1;
            end
            OP_MOUNT: begin
                // preferred slot first, else the highest free one
                if (c.protocol == PROTO_KBD && !seat_live[0]) s = 0;
                else if (c.protocol == PROTO_MOUSE && !seat_live[1]) s = 1;
                else if (c.protocol == PROTO_NONE && !seat_live[2]) s = 2;
                else if (c.protocol == PROTO_NONE && !seat_live[3]) s = 3;
                else
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (s < 0 && !seat_live[i]) s = i;
                if (s < 0) begin
                    r.status = ST_NO_FREE;
                end else begin
                    kind = DT_PAD;
                    keep = 1'b1;
                    if (c.protocol == PROTO_KBD) begin
                        kind = DT_KBD;
                    end else if (c.protocol == PROTO_MOUSE) begin
                        kind = DT_MOUSE;
                    end else if (c.protocol == PROTO_NONE) begin
                        if (c.is_touch) begin
                            kind = DT_TOUCH;
                            if (!(seat_live[3] && s != 3)) s = 3;
                        end else if (!c.is_gamepad) begin
                            keep = 1'b0;
                        end
                    end
                    if (!keep) begin
                        r.status = ST_IGNORED;
                    end else begin
                        delay = int'(regs.startup_base) + (s + 2) * int'(regs.startup_step);
                        seat_live[s]  = 1'b1;
                        seat_addr[s]  = c.addr;
                        seat_iface[s] = c.iface;
                        seat_kind[s]  = kind;
                        seat_busy[s]  = 1'b0;
                        seat_clock[s] = TIMER_W'(-delay);
                        seat_led[s]   = 1'b0;
                        r.slot        = OSLOT_W'(s);
                        r.dev_type    = kind;
                    end
                end
            end
            OP_UNMOUNT, OP_REPORT: begin
                for (int i = 0; i < SLOTS; i++)
                    if (s < 0 && seat_live[i] && seat_addr[i] == c.addr
                            && seat_iface[i] == c.iface)
                        s = i;
                if (s < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.slot     = OSLOT_W'(s);
                    r.dev_type = seat_kind[s];
                    seat_clock[s] = '0;
                    seat_busy[s]  = 1'b0;
                    if (c.op == OP_UNMOUNT) begin
                        // freed slot is parked busy so no poll ever picks it
                        seat_live[s]  = 1'b0;
                        seat_addr[s]  = '0;
                        seat_iface[s] = '0;
                        seat_kind[s]  = DT_NONE;
                        seat_led[s]   = 1'b0;
                        seat_busy[s]  = 1'b1;
                    end
                end
            end
            OP_POLL: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (seat_live[i] && !seat_busy[i] && int'(seat_clock[i]) >=
                            int'(seat_kind[i] == DT_TOUCH ? regs.touch_rate : regs.normal_rate))
                    begin
                        if (seat_kind[i] == DT_KBD && !seat_led[i]) begin
                            seat_led[i] = 1'b1;
                            r.led[i] = 1'b1;
                        end
                        // a refused request restarts the slot's count
                        if (c.accept[i]) begin
                            seat_busy[i] = 1'b1;
                            r.req[i] = 1'b1;
                        end else begin
                            seat_clock[i] = '0;
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // offer one word after a random gap, predict its result once it is taken;
    // valid stays up after acceptance so that a back-to-back word needs no toggle
    task automatic issue_word(input t_cmd c, input logic typed, input t_res want);
        int   gap;
        t_res r;
        if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            if (offering) cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.op          <= c.op;
        cmd_ch.usb_addr    <= c.addr;
        cmd_ch.iface       <= c.iface;
        cmd_ch.protocol    <= c.protocol;
        cmd_ch.is_touch    <= c.is_touch;
        cmd_ch.is_gamepad  <= c.is_gamepad;
        cmd_ch.accept_mask <= c.accept;
        offering = 1'b1;
        @(posedge i_clk);
        while (cmd_ch.ready !== 1'b1) @(posedge i_clk);
        r = scheduler_outcome(c);
        outcome_q.push_back(typed ? want : r);
        n_words++;
        if (c.op == OP_MOUNT && r.status == ST_OK) n_placed++;
        n_granted += $countones(r.req);
        n_leds += $countones(r.led);
    endtask

    // stop offering and wait until every result word has come back
    task automatic quiesce();
        if (offering) cmd_ch.valid <= 1'b0;
        offering = 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (SLOTS + 2) @(posedge i_clk);
    endtask

    // write all five registers on an idle block, one per cycle
    task automatic load_registers(input t_cfg v);
        quiesce();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_TOUCH_RATE;
        i_cfg_data <= CFG_DATA_W'(v.touch_rate);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_NORMAL_RATE;
        i_cfg_data <= CFG_DATA_W'(v.normal_rate);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_TIMER_CAP;
        i_cfg_data <= CFG_DATA_W'(v.timer_cap);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_STARTUP_BASE;
        i_cfg_data <= CFG_DATA_W'(v.startup_base);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_STARTUP_STEP;
        i_cfg_data <= CFG_DATA_W'(v.startup_step);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        regs = v;
        n_settings++;
    endtask

    // sender side: reset, directed table, then random phases
    initial begin : stimulus
        t_cmd c;
        t_cfg setting;
        int   pick;
        int   victim;
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= CFG_TOUCH_RATE;
        i_cfg_data         <= '0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.op          <= OP_TICK;
        cmd_ch.usb_addr    <= '0;
        cmd_ch.iface       <= '0;
        cmd_ch.protocol    <= PROTO_NONE;
        cmd_ch.is_touch    <= 1'b0;
        cmd_ch.is_gamepad  <= 1'b0;
        cmd_ch.accept_mask <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < PLAN_ROWS; k++) begin
            if (PLAN[k].kind == ROW_REGS) load_registers(PLAN[k].regs);
            else issue_word(PLAN[k].cmd, PLAN[k].kind == ROW_TYPED, PLAN[k].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            setting = PHASE_REGS[p];
            if (p == PHASES - 1) begin
                // small random schedule so that polls come due often
                setting.touch_rate   = RATE_W'($urandom_range(1, 12));
                setting.normal_rate  = RATE_W'($urandom_range(1, 30));
                setting.timer_cap    = CAP_W'($urandom_range(1, 64));
                setting.startup_base = RATE_W'($urandom_range(0, 20));
                setting.startup_step = RATE_W'($urandom_range(0, 10));
            end
            load_registers(setting);
            for (int n = 0; n < PHASE_WORDS[p]; n++) begin
                // all fields random, addresses and interfaces often from a small pool
                // so that duplicates and matches happen
                c.addr       = $urandom_range(0, 1) ? 7'($urandom_range(0, 127))
                                                    : 7'($urandom_range(0, 3));
                c.iface      = $urandom_range(0, 1) ? 4'($urandom_range(0, 15))
                                                    : 4'($urandom_range(0, 1));
                c.protocol   = 2'($urandom_range(0, 3));
                c.is_touch   = 1'($urandom_range(0, 1));
                c.is_gamepad = 1'($urandom_range(0, 1));
                c.accept     = 4'($urandom_range(0, 15));
                pick = $urandom_range(0, 99);
                if (pick < 35) c.op = OP_TICK;
                else if (pick < 60) c.op = OP_POLL;
                else if (pick < 76) c.op = OP_MOUNT;
                else if (pick < 88) c.op = OP_UNMOUNT;
                else if (pick < 96) c.op = OP_REPORT;
                else c.op = OP_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
                // most unmounts and reports aim at a device that is really there
                if ((c.op == OP_UNMOUNT || c.op == OP_REPORT) && $urandom_range(0, 3) != 0)
                begin
                    victim = $urandom_range(0, SLOTS - 1);
                    if (seat_live[victim]) begin
                        c.addr  = seat_addr[victim];
                        c.iface = seat_iface[victim];
                    end
                end
                issue_word(c, 1'b0, ZERO_RES);
            end
        end

        quiesce();
        repeat (SLOTS + 4) @(posedge i_clk);
        $display("covered %0d command words over %0d register settings", n_words, n_settings);
        $display("%0d devices placed, %0d report requests granted, %0d led pushes",
                 n_placed, n_granted, n_leds);
        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // receiver side: random ready, one long hold-off, field-by-field check
    initial begin : collect
        int   gap;
        int   got;
        t_res want;
        got = 0;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
            gap = rx_calm ? 0 : $urandom_range(0, 15);
            if (got == HOLD_AFTER) gap = HOLD_CYCLES;
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (res_ch.valid !== 1'b1) @(posedge i_clk);
            got++;
            if (outcome_q.size() == 0) begin
                $error("result word with no command outstanding");
                mismatches++;
            end else begin
                want = outcome_q.pop_front();
                if (res_ch.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, res_ch.status);
                    mismatches++;
                end
                if (res_ch.slot !== want.slot) begin
                    $error("slot: expected %0d, actual %0d", want.slot, res_ch.slot);
                    mismatches++;
                end
                if (res_ch.dev_type !== want.dev_type) begin
                    $error("dev_type: expected %0d, actual %0d", want.dev_type,
                           res_ch.dev_type);
                    mismatches++;
                end
                if (res_ch.request_mask !== want.req) begin
                    $error("request_mask: expected %0h, actual %0h", want.req,
                           res_ch.request_mask);
                    mismatches++;
                end
                if (res_ch.led_mask !== want.led) begin
                    $error("led_mask: expected %0h, actual %0h", want.led, res_ch.led_mask);
                    mismatches++;
                end
            end
        end
    end

    // watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #(10_000_000);
        $display("timeout with %0d result words outstanding", outcome_q.size());
        $display("testbench NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/hsps_pkg.sv
rtl/core/hsps_in_if.sv
rtl/core/hsps_out_if.sv
rtl/core/hsps_timer_unit.sv
rtl/core/hsps_slot_pick.sv
rtl/core/hid_slot_poll_scheduler.sv
tb/sv/testbench.sv
